@@ rtl/moip_pkg.sv @@
// Shared types and constants of the min offset index packer.
package moip_pkg;

	localparam int VALUE_W   = 32;
	localparam int CODE_W    = 2;
	localparam int CFG_IDX_W = 8;
	localparam int CFG_DATA_W = 32;

	// Lane width codes as they appear on the result items.
	localparam logic [CODE_W-1:0] LANE_W8  = 2'd0;
	localparam logic [CODE_W-1:0] LANE_W16 = 2'd1;
	localparam logic [CODE_W-1:0] LANE_W32 = 2'd2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_FORCE_WORD = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SIGNED     = 8'd1;

	// Extreme start values for each compare mode.
	localparam logic [VALUE_W-1:0] SMIN_START = 32'h7FFF_FFFF;
	localparam logic [VALUE_W-1:0] SMAX_START = 32'h8000_0000;
	localparam logic [VALUE_W-1:0] UMIN_START = 32'hFFFF_FFFF;
	localparam logic [VALUE_W-1:0] UMAX_START = 32'h0000_0000;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept_in;
		logic calc;
		logic rd_issue;
		logic acc_step;
		logic out_take;
	} ctrl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic word_done;
		logic out_last;
	} dp_status_t;

endpackage

@@ rtl/moip_if.sv @@
// Handshake channel interfaces for values, packed words and configuration writes.
interface moip_value_if;
	import moip_pkg::*;
	logic               valid;
	logic               ready;
	logic [VALUE_W-1:0] index_value;
	logic               set_last;
	modport source (output valid, output index_value, output set_last, input ready);
	modport sink (input valid, input index_value, input set_last, output ready);
endinterface

interface moip_word_if;
	import moip_pkg::*;
	logic               valid;
	logic               ready;
	logic [VALUE_W-1:0] packed_word;
	logic [CODE_W-1:0]  lane_width_code;
	logic [VALUE_W-1:0] shift_offset;
	logic               word_last;
	modport source (output valid, output packed_word, output lane_width_code,
		output shift_offset, output word_last, input ready);
	modport sink (input valid, input packed_word, input lane_width_code,
		input shift_offset, input word_last, output ready);
endinterface

interface moip_cfg_if;
	import moip_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

@@ rtl/moip_datapath.sv @@
// Datapath: value store, running extremes, lane width choice and word assembly.
module moip_datapath import moip_pkg::*; #(
	parameter int MAX_VALUES = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ctrl_cmd_t             cmd,
	output dp_status_t            status,
	input  logic [VALUE_W-1:0]    index_value,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output logic [VALUE_W-1:0]    packed_word,
	output logic [CODE_W-1:0]     lane_width_code,
	output logic [VALUE_W-1:0]    shift_offset,
	output logic                  word_last
);

	localparam int IDX_W = (MAX_VALUES > 1) ? $clog2(MAX_VALUES) : 1;
	localparam int CNT_W = $clog2(MAX_VALUES + 1);

	logic               force_word_q;
	logic               signed_q;
	logic [CNT_W-1:0]   count_q;
	logic [VALUE_W-1:0] min_q;
	logic [VALUE_W-1:0] max_q;
	logic [VALUE_W-1:0] mem [MAX_VALUES];
	logic [VALUE_W-1:0] rd_data_q;
	logic [IDX_W-1:0]   rd_ptr_q;
	logic [1:0]         lane_q;
	logic [VALUE_W-1:0] acc_q;
	logic [CODE_W-1:0]  code_q;
	logic [VALUE_W-1:0] offset_q;
	logic [VALUE_W-1:0] out_word_q;
	logic               out_last_q;

	logic               store_ok;
	logic               v_lt_min;
	logic               max_lt_v;
	logic [VALUE_W-1:0] range;
	logic [VALUE_W-1:0] lane_sum;
	logic [VALUE_W-1:0] acc_next;
	logic               lane_last;
	logic               value_last;

	// Mode-aware compares: flipping the sign bit turns a signed compare into unsigned.
	assign store_ok = count_q < CNT_W'(MAX_VALUES);
	assign v_lt_min = ({index_value[31] ^ signed_q, index_value[30:0]} <
		{min_q[31] ^ signed_q, min_q[30:0]});
	assign max_lt_v = ({max_q[31] ^ signed_q, max_q[30:0]} <
		{index_value[31] ^ signed_q, index_value[30:0]});
	assign range = max_q - min_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			force_word_q <= 1'b0;
			signed_q     <= 1'b1;
		end else if (cfg_we) begin
			if (cfg_index == CFG_FORCE_WORD) begin
				force_word_q <= cfg_data[0];
			end
			if (cfg_index == CFG_SIGNED) begin
				signed_q <= cfg_data[0];
			end
		end
	end

	// Value store: written while loading, read one entry per store read command while packing.
	always_ff @(posedge clk) begin
		if (cmd.accept_in && store_ok) begin
			mem[count_q[IDX_W-1:0]] <= index_value;
		end
		if (cmd.rd_issue) begin
			rd_data_q <= mem[rd_ptr_q];
		end
	end

	// Fill count and running extremes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			min_q   <= SMIN_START;
			max_q   <= SMAX_START;
		end else if (cmd.accept_in && store_ok) begin
			count_q <= count_q + CNT_W'(1);
			if (count_q == '0) begin
				min_q <= index_value;
				max_q <= index_value;
			end else begin
				if (v_lt_min) begin
					min_q <= index_value;
				end
				if (max_lt_v) begin
					max_q <= index_value;
				end
			end
		end else if (cmd.out_take && out_last_q) begin
			count_q <= '0;
			min_q   <= signed_q ? SMIN_START : UMIN_START;
			max_q   <= signed_q ? SMAX_START : UMAX_START;
		end
	end

	// Lane insertion of the current value into the word being assembled.
	assign lane_sum = rd_data_q + offset_q;
	always_comb begin
		case (code_q)
			LANE_W8: begin
				acc_next  = acc_q | ({24'b0, lane_sum[7:0]} << {lane_q, 3'b000});
				lane_last = (lane_q == 2'd3);
			end
			LANE_W16: begin
				acc_next  = acc_q | ({16'b0, lane_sum[15:0]} << {lane_q[0], 4'b0000});
				lane_last = lane_q[0];
			end
			default: begin
				acc_next  = lane_sum;
				lane_last = 1'b1;
			end
		endcase
	end
	assign value_last = (CNT_W'(rd_ptr_q) == (count_q - CNT_W'(1)));

	// Packing pass: lane width choice, read pointer, accumulator and output word.
	always_ff @(posedge clk) begin
		if (cmd.calc) begin
			offset_q <= '0 - min_q;
			rd_ptr_q <= '0;
			lane_q   <= '0;
			acc_q    <= '0;
			if (force_word_q) begin
				code_q <= LANE_W32;
			end else if (range[31:8] == '0) begin
				code_q <= LANE_W8;
			end else if (range[31:16] == '0) begin
				code_q <= LANE_W16;
			end else begin
				code_q <= LANE_W32;
			end
		end
		if (cmd.acc_step) begin
			if (lane_last || value_last) begin
				out_word_q <= acc_next;
				out_last_q <= value_last;
				acc_q      <= '0;
			end else begin
				acc_q    <= acc_next;
				lane_q   <= lane_q + 2'd1;
				rd_ptr_q <= rd_ptr_q + IDX_W'(1);
			end
		end
		if (cmd.out_take && !out_last_q) begin
			rd_ptr_q <= rd_ptr_q + IDX_W'(1);
			lane_q   <= '0;
		end
	end

	assign status.word_done = lane_last || value_last;
	assign status.out_last  = out_last_q;

	assign packed_word     = out_word_q;
	assign lane_width_code = code_q;
	assign shift_offset    = offset_q;
	assign word_last       = out_last_q;

endmodule

@@ rtl/moip_ctrl.sv @@
// Controller: sequences loading, lane width choice, store reads and word delivery.
module moip_ctrl import moip_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_last,
	input  logic       out_ready,
	input  dp_status_t status,
	output ctrl_cmd_t  cmd,
	output logic       in_ready,
	output logic       out_valid
);

	typedef enum logic [2:0] {
		S_LOAD,
		S_CALC,
		S_READ,
		S_ACC,
		S_OUT
	} state_t;

	state_t state_q;
	logic   in_ready_q;
	logic   out_valid_q;

	// Commands follow the state and the handshakes.
	assign cmd.accept_in = in_ready_q && in_valid;
	assign cmd.calc      = (state_q == S_CALC);
	assign cmd.rd_issue  = (state_q == S_READ);
	assign cmd.acc_step  = (state_q == S_ACC);
	assign cmd.out_take  = out_valid_q && out_ready;

	// State register with registered handshake outputs.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_LOAD;
			in_ready_q  <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_LOAD: begin
					if (in_valid && in_last) begin
						state_q    <= S_CALC;
						in_ready_q <= 1'b0;
					end
				end
				S_CALC: begin
					state_q <= S_READ;
				end
				S_READ: begin
					state_q <= S_ACC;
				end
				S_ACC: begin
					if (status.word_done) begin
						state_q     <= S_OUT;
						out_valid_q <= 1'b1;
					end else begin
						state_q <= S_READ;
					end
				end
				S_OUT: begin
					if (out_ready) begin
						out_valid_q <= 1'b0;
						if (status.out_last) begin
							state_q    <= S_LOAD;
							in_ready_q <= 1'b1;
						end else begin
							state_q <= S_READ;
						end
					end
				end
				default: begin
					state_q <= S_LOAD;
				end
			endcase
		end
	end

	assign in_ready  = in_ready_q;
	assign out_valid = out_valid_q;

endmodule

@@ rtl/min_offset_index_packer_top.sv @@
// Loading takes one value item per cycle; a value marked last starts the packing pass.
// In the packing pass the controller chooses the lane width (S_CALC), then for each value
// does one store read (S_READ) and one lane insert (S_ACC) until the word is complete, and
// offers it (S_OUT); after each non-final word is taken it goes back to reading. No new
// value is accepted until the final word of the set has been taken.
// Reset empties the fill count, returns the controller to loading and sets the mode
// registers to signed compare with automatic lane width; the store keeps its contents.
module min_offset_index_packer_top import moip_pkg::*; #(
	parameter int MAX_VALUES = 64
) (
	input  logic clk,
	input  logic arst_n,
	moip_value_if.sink   values,
	moip_word_if.source  words,
	moip_cfg_if.sink     cfg
);

	ctrl_cmd_t  cmd;
	dp_status_t status;

	// Configuration writes are always taken.
	assign cfg.ready = 1'b1;

	// Sequencing of the loading and packing passes.
	moip_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (values.valid),
		.in_last   (values.set_last),
		.out_ready (words.ready),
		.status    (status),
		.cmd       (cmd),
		.in_ready  (values.ready),
		.out_valid (words.valid)
	);

	// Storage, extremes and word assembly.
	moip_datapath #(
		.MAX_VALUES (MAX_VALUES)
	) u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.status          (status),
		.index_value     (values.index_value),
		.cfg_we          (cfg.valid),
		.cfg_index       (cfg.index),
		.cfg_data        (cfg.data),
		.packed_word     (words.packed_word),
		.lane_width_code (words.lane_width_code),
		.shift_offset    (words.shift_offset),
		.word_last       (words.word_last)
	);

endmodule

@@ bench/min_offset_index_packer_top_test.sv @@
// Self-checking testbench for the frame-of-reference index packer top level.
`timescale 1ns / 1ps

module min_offset_index_packer_top_test;
	import moip_pkg::*;

	localparam int SET_CAPACITY = 64;
	localparam int RANDOM_VALUES = 40;
	localparam int SETTLE_CYCLES = 12;
	localparam int CYCLE_LIMIT = 300000;
	localparam int PRINT_CAP = 40;

	// One packed word as the block should deliver it.
	typedef struct {
		logic [VALUE_W-1:0] word;
		logic [CODE_W-1:0]  code;
		logic [VALUE_W-1:0] offset;
		logic               final_word;
	} packed_word_t;

	logic clk = 1'b0;
	logic arst_n;

	moip_value_if value_bus();
	moip_word_if  word_bus();
	moip_cfg_if   cfg_bus();

	min_offset_index_packer_top #(
		.MAX_VALUES(SET_CAPACITY)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.values(value_bus),
		.words(word_bus),
		.cfg(cfg_bus)
	);

	// Mirror of the block's state, updated as items and register writes are accepted.
	logic [VALUE_W-1:0] held_values [SET_CAPACITY];
	int unsigned        held_count;
	logic [VALUE_W-1:0] low_mark;
	logic [VALUE_W-1:0] high_mark;
	logic               force_wide;
	logic               signed_mode;
	packed_word_t       pending_words [$];

	int unsigned mismatches;
	int unsigned values_sent;
	int unsigned sets_packed;
	int unsigned words_checked;
	int unsigned code_seen [3];
	int unsigned cycle_count;
	int unsigned word_hold_left;
	int unsigned ready_gap_left;
	int unsigned calm_left;
	bit          calm;
	bit          steady;

	always #5 clk = ~clk;

	// Run limit, so that a hung handshake cannot stall the regression.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d words still pending.", cycle_count,
				pending_words.size());
			$display("Regression FAIL");
			$finish;
		end
	end

	// Alternate stretches with and without idling on both sides.
	always @(posedge clk) begin
		if (calm_left == 0) begin
			calm = ($urandom_range(0, 3) == 0);
			calm_left = $urandom_range(20, 60);
		end else begin
			calm_left--;
		end
	end

	// Word receiver: a long hold when requested, otherwise short random bursts of stall.
	always @(posedge clk) begin
		if (word_hold_left != 0) begin
			word_bus.ready <= 1'b0;
			word_hold_left--;
		end else if (ready_gap_left != 0) begin
			word_bus.ready <= 1'b0;
			ready_gap_left--;
		end else if (!steady && !calm && $urandom_range(0, 4) == 0) begin
			word_bus.ready <= 1'b0;
			ready_gap_left = $urandom_range(0, 3);
		end else begin
			word_bus.ready <= 1'b1;
		end
	end

	task automatic report_mismatch(input string what, input logic [VALUE_W-1:0] got,
		input logic [VALUE_W-1:0] want);
		mismatches++;
		if (mismatches <= PRINT_CAP)
			$display("Mismatch at cycle %0d, %s: got %h, wanted %h", cycle_count, what, got,
				want);
	endtask

	// Compare each accepted packed word with the oldest one predicted.
	always @(posedge clk) begin
		packed_word_t want;
		if (arst_n && word_bus.valid && word_bus.ready) begin
			if (pending_words.size() == 0) begin
				report_mismatch("word with none pending", word_bus.packed_word, '0);
			end else begin
				want = pending_words.pop_front();
				words_checked++;
				if (want.code <= LANE_W32)
					code_seen[want.code]++;
				if (word_bus.packed_word !== want.word)
					report_mismatch("packed_word", word_bus.packed_word, want.word);
				if (word_bus.lane_width_code !== want.code)
					report_mismatch("lane_width_code", VALUE_W'(word_bus.lane_width_code),
						VALUE_W'(want.code));
				if (word_bus.shift_offset !== want.offset)
					report_mismatch("shift_offset", word_bus.shift_offset, want.offset);
				if (word_bus.word_last !== want.final_word)
					report_mismatch("word_last", VALUE_W'(word_bus.word_last),
						VALUE_W'(want.final_word));
			end
		end
	end

	// Ordering under the current compare mode.
	function automatic bit value_below(input logic [VALUE_W-1:0] a,
		input logic [VALUE_W-1:0] b);
		if (signed_mode)
			return (a ^ 32'h8000_0000) < (b ^ 32'h8000_0000);
		return a < b;
	endfunction

	// Take one accepted value; on the last of a set, predict the whole packed set.
	function automatic void take_value(input logic [VALUE_W-1:0] v, input logic is_last);
		packed_word_t       r;
		logic [VALUE_W-1:0] span;
		logic [VALUE_W-1:0] offset;
		logic [VALUE_W-1:0] mask;
		logic [VALUE_W-1:0] lane;
		logic [CODE_W-1:0]  code;
		int unsigned        lanes;
		int unsigned        bits;
		int unsigned        n_words;
		int unsigned        idx;
		// A value arriving on a full store is dropped without being compared.
		if (held_count < SET_CAPACITY) begin
			held_values[held_count] = v;
			if (held_count == 0) begin
				low_mark = v;
				high_mark = v;
			end else begin
				if (value_below(v, low_mark))
					low_mark = v;
				if (value_below(high_mark, v))
					high_mark = v;
			end
			held_count++;
		end
		if (!is_last || held_count == 0)
			return;
		span = high_mark - low_mark;
		offset = 32'd0 - low_mark;
		if (force_wide || span > 32'd65535) begin
			code = LANE_W32;
			lanes = 1;
			bits = 32;
		end else if (span > 32'd255) begin
			code = LANE_W16;
			lanes = 2;
			bits = 16;
		end else begin
			code = LANE_W8;
			lanes = 4;
			bits = 8;
		end
		mask = (bits == 32) ? 32'hFFFF_FFFF : ((32'd1 << bits) - 32'd1);
		n_words = (held_count + lanes - 1) / lanes;
		for (int w = 0; w < n_words; w++) begin
			r.word = '0;
			for (int l = 0; l < lanes; l++) begin
				idx = w * lanes + l;
				if (idx < held_count) begin
					lane = (held_values[idx] + offset) & mask;
					r.word |= lane << (l * bits);
				end
			end
			r.code = code;
			r.offset = offset;
			r.final_word = (w + 1 == n_words);
			pending_words.push_back(r);
		end
		held_count = 0;
		sets_packed++;
	endfunction

	// Offer one value item, with an occasional random gap in front of it.
	task automatic send_value(input logic [VALUE_W-1:0] v, input logic is_last);
		int unsigned gap;
		if (!steady && !calm && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 4);
			value_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		value_bus.valid <= 1'b1;
		value_bus.index_value <= v;
		value_bus.set_last <= is_last;
		@(posedge clk);
		while (!value_bus.ready) @(posedge clk);
		take_value(v, is_last);
		values_sent++;
	endtask

	task automatic send_set(input logic [VALUE_W-1:0] vals [$]);
		foreach (vals[i])
			send_value(vals[i], i == vals.size() - 1);
	endtask

	// Stop offering values, wait for every predicted word, then let the block settle.
	task automatic drain_words();
		value_bus.valid <= 1'b0;
		@(posedge clk);
		while (pending_words.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Register writes happen only with no packed word pending and no value offered.
	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] data);
		drain_words();
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data <= data;
		@(posedge clk);
		while (!cfg_bus.ready) @(posedge clk);
		cfg_bus.valid <= 1'b0;
		if (idx == CFG_FORCE_WORD)
			force_wide = data[0];
		else if (idx == CFG_SIGNED)
			signed_mode = data[0];
	endtask

	// Random value near a base, with a spread that favours one lane width; any other kind is fully random.
	function automatic logic [VALUE_W-1:0] spread_value(input logic [VALUE_W-1:0] base,
		input int unsigned kind);
		case (kind)
			0: begin
				return base + $urandom_range(0, 255);
			end
			1: begin
				return base + $urandom_range(0, 65535);
			end
			default: begin
				return $urandom;
			end
		endcase
	endfunction

	// Range edges of each lane width under the reset mode (signed, not forced).
	task automatic test_lane_widths();
		send_set('{32'h0000_0000});
		send_set('{32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0001, 32'hFFFF_FF01, 32'h0000_007F});
		send_set('{32'h8000_0000, 32'h8000_00FF});
		send_set('{32'h0000_0000, 32'h0000_0100});
		send_set('{32'h1234_FFFF, 32'h1234_0000});
		send_set('{32'h0000_0000, 32'h0001_0000});
		send_set('{32'h7FFF_FFFF, 32'h8000_0000});
	endtask

	// Unsigned compare: all-ones is the maximum, not minus one.
	task automatic test_unsigned_compare();
		write_register(CFG_SIGNED, 32'd0);
		send_set('{32'hFFFF_FFFF, 32'h0000_0000});
		send_set('{32'hFFFF_FF00, 32'hFFFF_FFFF, 32'hFFFF_FF80});
	endtask

	// Forced full width whatever the range, then back to automatic choice.
	task automatic test_forced_word_width();
		write_register(CFG_FORCE_WORD, 32'd1);
		send_set('{32'h0000_0003, 32'h0000_0004, 32'h0000_0005});
		write_register(CFG_FORCE_WORD, 32'd0);
	endtask

	// Compare mode flipped while a set is half loaded, in both directions.
	task automatic test_mode_change_mid_set();
		send_value(32'h0000_0010, 1'b0);
		send_value(32'hFFFF_FFF0, 1'b0);
		write_register(CFG_SIGNED, 32'd1);
		send_value(32'h0000_0008, 1'b1);
		send_value(32'hFFFF_FFF0, 1'b0);
		send_value(32'h0000_0010, 1'b0);
		write_register(CFG_SIGNED, 32'd0);
		send_value(32'hFFFF_FFF8, 1'b1);
		write_register(CFG_SIGNED, 32'd1);
	endtask

	// A full store drops further values, including one marked last, and still packs.
	task automatic test_store_overflow();
		logic [VALUE_W-1:0] base;
		base = $urandom;
		for (int i = 0; i < SET_CAPACITY; i++)
			send_value(base + $urandom_range(0, 200), 1'b0);
		send_value(32'hDEAD_0000, 1'b0);
		send_value(32'hFFFF_FFFF, 1'b1);
		for (int i = 0; i < SET_CAPACITY; i++)
			send_value(spread_value(base, 1), i == SET_CAPACITY - 1);
	endtask

	// Hold the word output for a long stretch while sets keep coming, so input stalls.
	task automatic test_output_backpressure();
		logic [VALUE_W-1:0] base;
		drain_words();
		word_hold_left = 400;
		for (int s = 0; s < 3; s++) begin
			base = $urandom;
			for (int i = 0; i < 8; i++)
				send_value(spread_value(base, s), i == 7);
		end
	endtask

	// Random sets of random size and spread, with register changes in between.
	task automatic test_random_sets();
		logic [VALUE_W-1:0] base;
		int unsigned        set_size;
		int unsigned        kind;
		int unsigned        flip_at;
		int unsigned        sent_here;
		sent_here = 0;
		while (sent_here < RANDOM_VALUES) begin
			if (sent_here >= RANDOM_VALUES - 20)
				steady = 1'b1;
			if ($urandom_range(0, 5) == 0)
				write_register($urandom_range(0, 1) ? CFG_SIGNED : CFG_FORCE_WORD, $urandom);
			set_size = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 70)
				: $urandom_range(1, 12);
			if (set_size > RANDOM_VALUES - sent_here)
				set_size = RANDOM_VALUES - sent_here;
			kind = $urandom_range(0, 3);
			base = $urandom;
			flip_at = ($urandom_range(0, 9) == 0) ? $urandom_range(1, set_size) : set_size;
			for (int i = 0; i < set_size; i++) begin
				if (i == flip_at && i != 0)
					write_register(CFG_SIGNED, {31'd0, !signed_mode});
				send_value(spread_value(base, kind), i == set_size - 1);
			end
			sent_here += set_size;
		end
	endtask

	initial begin
		arst_n = 1'b0;
		value_bus.valid = 1'b0;
		value_bus.index_value = '0;
		value_bus.set_last = 1'b0;
		word_bus.ready = 1'b0;
		cfg_bus.valid = 1'b0;
		cfg_bus.index = '0;
		cfg_bus.data = '0;
		held_count = 0;
		force_wide = 1'b0;
		signed_mode = 1'b1;
		low_mark = SMIN_START;
		high_mark = SMAX_START;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_lane_widths();
		test_unsigned_compare();
		test_forced_word_width();
		test_mode_change_mid_set();
		test_store_overflow();
		test_output_backpressure();
		test_random_sets();

		drain_words();
		$display("Covered %0d value items in %0d sets; %0d packed words checked.",
			values_sent, sets_packed, words_checked);
		$display("Words by lane width: 8-bit %0d, 16-bit %0d, 32-bit %0d; %0d mismatches.",
			code_seen[0], code_seen[1], code_seen[2], mismatches);
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/moip_pkg.sv
rtl/moip_if.sv
rtl/moip_datapath.sv
rtl/moip_ctrl.sv
rtl/min_offset_index_packer_top.sv
bench/min_offset_index_packer_top_test.sv
